@@ rtl/osm_pkg.sv @@
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants
// Widths, operation and status codes and sequencer states of the ordered
// multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

	localparam int ENTRIES = 1024;
	localparam int VAL_W   = 32;
	localparam int MULT_W  = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SUM_W   = MULT_W + CNT_W;
	localparam int ENT_W   = VAL_W + MULT_W;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_RANK   = 3'd2;
	localparam logic [2:0] MODE_KTH    = 3'd3;
	localparam logic [2:0] MODE_PRED   = 3'd4;
	localparam logic [2:0] MODE_SUCC   = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic signed [VAL_W-1:0] SENT_HIGH = 32'sh3f3f3f3f;
	localparam logic signed [VAL_W-1:0] SENT_LOW  = 32'shcfcfcfcf;
	localparam logic [MULT_W-1:0]       MULT_MAX  = 16'hffff;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_POST,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ENT_W-1:0] wdata;
	} mem_req_t;

endpackage

@@ rtl/osm_if.sv @@
// ----------------------------------------------------------------------------
// osm_in_if / osm_out_if: valid-ready channels
// Operation channel into the multiset and result channel out of it.
// ----------------------------------------------------------------------------
interface osm_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] operand;

	modport source (output valid, mode, operand, input ready);
	modport sink   (input valid, mode, operand, output ready);
endinterface

interface osm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] answer;
	logic [1:0]         status;

	modport source (output valid, answer, status, input ready);
	modport sink   (input valid, answer, status, output ready);
endinterface

@@ rtl/osm_ram.sv @@
// ----------------------------------------------------------------------------
// osm_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module osm_ram #(
	parameter int DATA_W = 48,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/osm_ctrl.sv @@
// ----------------------------------------------------------------------------
// osm_ctrl: multiset sequencer
// Scans the sorted entry memory, resolves each operation and shifts entries
// to open or close a slot on insert and delete.
// ----------------------------------------------------------------------------
module osm_ctrl
	import osm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	osm_in_if.sink           in_ch,
	osm_out_if.source        out_ch,
	output mem_req_t         mem_req,
	input  logic [ENT_W-1:0] rdata
);

	state_t state_q, state_d;

	logic [2:0]               mode_q;
	logic signed [VAL_W-1:0]  x_q;
	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         p_q;
	logic [SUM_W-1:0]         below_q;
	logic signed [VAL_W-1:0]  last_v_q;
	logic signed [VAL_W-1:0]  hv_q;
	logic [MULT_W-1:0]        hm_q;
	logic                     hit_q;
	logic                     found_q;
	logic signed [VAL_W-1:0]  ans_q;
	logic [1:0]               st_q;
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  out_answer_q;
	logic [1:0]               out_status_q;

	logic signed [VAL_W-1:0]  rv;
	logic [MULT_W-1:0]        rm;
	logic [SUM_W-1:0]         seen;
	logic                     ev_stop;
	logic                     ev_last;
	logic                     in_take;
	logic                     is_ins;

	assign rv      = $signed(rdata[ENT_W-1:MULT_W]);
	assign rm      = rdata[MULT_W-1:0];
	assign seen    = below_q + SUM_W'(rm);
	assign ev_last = (idx_q + CNT_W'(1)) == used_q;
	assign in_take = in_ch.valid && in_ch.ready;
	assign is_ins  = mode_q == MODE_INSERT;

	always_comb begin
		unique case (mode_q)
			MODE_KTH:  ev_stop = {{(VAL_W-SUM_W){1'b0}}, seen} >= $unsigned(x_q);
			MODE_SUCC: ev_stop = rv > x_q;
			default:   ev_stop = rv >= x_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					if (in_ch.mode > MODE_SUCC ||
					    (in_ch.mode == MODE_KTH && in_ch.operand < 32'sd1)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: state_d = (idx_q == used_q) ? S_POST : S_EV;
			S_EV: state_d = (ev_stop || ev_last) ? S_POST : S_RD;
			S_POST: begin
				if ((is_ins && !hit_q && used_q != CNT_W'(ENTRIES)) ||
				    (mode_q == MODE_DELETE && hit_q && hm_q == MULT_W'(1))) begin
					state_d = S_SH_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SH_RD: begin
				if (is_ins ? (idx_q > p_q) : (idx_q + CNT_W'(1) < used_q)) begin
					state_d = S_SH_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SH_WR: state_d = S_SH_RD;
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready   = state_q == S_IDLE;
		mem_req.re    = 1'b0;
		mem_req.raddr = idx_q[IDX_W-1:0];
		mem_req.we    = 1'b0;
		mem_req.waddr = p_q[IDX_W-1:0];
		mem_req.wdata = {hv_q, hm_q};
		unique case (state_q)
			S_RD: mem_req.re = idx_q != used_q;
			S_POST: begin
				if (hit_q && is_ins && hm_q != MULT_MAX) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = {hv_q, hm_q + MULT_W'(1)};
				end else if (hit_q && mode_q == MODE_DELETE && hm_q > MULT_W'(1)) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = {hv_q, hm_q - MULT_W'(1)};
				end
			end
			S_SH_RD: begin
				if (is_ins) begin
					mem_req.raddr = IDX_W'(idx_q - CNT_W'(1));
					mem_req.re    = idx_q > p_q;
					// slot opened: drop the new value in
					mem_req.we    = !(idx_q > p_q);
					mem_req.wdata = {x_q, MULT_W'(1)};
				end else begin
					mem_req.raddr = IDX_W'(idx_q + CNT_W'(1));
					mem_req.re    = idx_q + CNT_W'(1) < used_q;
				end
			end
			S_SH_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q[IDX_W-1:0];
				mem_req.wdata = rdata;
			end
			default: ;
		endcase
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.answer = out_answer_q;
	assign out_ch.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SH_RD: begin
					if (is_ins && !(idx_q > p_q)) begin
						used_q <= used_q + CNT_W'(1);
					end else if (!is_ins && !(idx_q + CNT_W'(1) < used_q)) begin
						used_q <= used_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mode_q   <= in_ch.mode;
				x_q      <= in_ch.operand;
				idx_q    <= '0;
				p_q      <= '0;
				below_q  <= '0;
				hit_q    <= 1'b0;
				found_q  <= 1'b0;
				if (in_ch.mode > MODE_SUCC) begin
					st_q  <= ST_MISSING;
					ans_q <= '0;
				end else if (in_ch.mode == MODE_KTH && in_ch.operand < 32'sd1) begin
					st_q  <= ST_MISSING;
					ans_q <= SENT_LOW;
				end else begin
					st_q  <= ST_OK;
					ans_q <= '0;
				end
			end
			S_RD: begin
				if (idx_q == used_q) begin
					p_q <= used_q;
				end
			end
			S_EV: begin
				if (ev_stop) begin
					p_q     <= idx_q;
					hv_q    <= rv;
					hm_q    <= rm;
					hit_q   <= rv == x_q;
					found_q <= 1'b1;
					ans_q   <= rv;
				end else begin
					below_q  <= (mode_q == MODE_KTH) ? seen : below_q + SUM_W'(rm);
					last_v_q <= rv;
					idx_q    <= idx_q + CNT_W'(1);
					if (ev_last) begin
						p_q <= used_q;
					end
				end
			end
			S_POST: begin
				unique case (mode_q)
					MODE_INSERT: begin
						ans_q <= '0;
						if (hit_q ? (hm_q == MULT_MAX) : (used_q == CNT_W'(ENTRIES))) begin
							st_q <= ST_FULL;
						end
						idx_q <= hit_q ? p_q : used_q;
					end
					MODE_DELETE: begin
						ans_q <= '0;
						if (!hit_q) begin
							st_q <= ST_MISSING;
						end
						idx_q <= p_q;
					end
					MODE_RANK: ans_q <= VAL_W'(below_q) + 32'sd1;
					MODE_PRED: begin
						if (p_q == '0) begin
							ans_q <= SENT_LOW;
							st_q  <= ST_MISSING;
						end else begin
							ans_q <= last_v_q;
						end
					end
					default: begin
						if (!found_q) begin
							ans_q <= SENT_HIGH;
							st_q  <= ST_MISSING;
						end
					end
				endcase
			end
			S_SH_WR: idx_q <= is_ins ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_answer_q <= ans_q;
					out_status_q <= st_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/order_statistic_multiset_top.sv @@
// ----------------------------------------------------------------------------
// order_statistic_multiset_top: ordered multiset of signed 32-bit values
// Sorted distinct values with multiplicities in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per transaction (mode, operand); out_ch returns
//   one result per operation (answer, status), in order.
//   Each operation with a valid mode and operand scans the entry RAM from the
//   lowest entry, reading then evaluating each entry visited, since the RAM
//   has one read port with a registered output. An insert of a new value or
//   a delete of a last copy then shifts the entries above the slot, reading
//   then writing each moved entry.
//   One operation is in flight at a time; in_ch.ready is high while idle.
//   The result sits in an output register; a stalled receiver holds it there,
//   and the next operation may be taken and worked while it waits.
//   Reset empties the multiset at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top
	import osm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	osm_in_if.sink    in_ch,
	osm_out_if.source out_ch
);

	mem_req_t         mem_req;
	logic [ENT_W-1:0] rdata;

	osm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	osm_ram #(
		.DATA_W (ENT_W),
		.DEPTH  (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

endmodule

@@ tb/order_statistic_multiset_top_tb.sv @@
// ----------------------------------------------------------------------------
// order_statistic_multiset_top_tb: self-checking bench for the ordered multiset
// Drives operations from a queue, predicts each result with a sorted-array
// model of the multiset, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top_tb;
	import osm_pkg::*;

	typedef struct {
		logic [2:0]         mode;
		logic signed [31:0] operand;
	} op_t;

	typedef struct {
		logic signed [31:0] answer;
		logic [1:0]         status;
	} res_t;

	localparam int STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	osm_in_if  in_ch();
	osm_out_if out_ch();

	order_statistic_multiset_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	// multiset shadow: distinct values ascending, with counts
	logic signed [31:0] set_vals[$];
	int unsigned        set_cnts[$];

	op_t  pending_ops[$];
	res_t expected_results[$];
	int   mismatches = 0;
	bit   hold_sink = 0;
	bit   hold_source = 0;
	bit   no_idle = 0;
	int   quiet_cycles = 0;

	function automatic int unsigned lower_slot(logic signed [31:0] x);
		int unsigned i;
		i = 0;
		while (i < set_vals.size() && set_vals[i] < x)
			i++;
		return i;
	endfunction

	function automatic res_t predict_result(op_t op);
		res_t r;
		int unsigned p;
		longint unsigned seen;
		r.answer = '0;
		r.status = ST_OK;
		p = lower_slot(op.operand);
		case (op.mode)
			MODE_INSERT: begin
				if (p < set_vals.size() && set_vals[p] == op.operand) begin
					if (set_cnts[p] >= MULT_MAX)
						r.status = ST_FULL;
					else
						set_cnts[p]++;
				end else if (set_vals.size() >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					set_vals.insert(p, op.operand);
					set_cnts.insert(p, 1);
				end
			end
			MODE_DELETE: begin
				if (p >= set_vals.size() || set_vals[p] != op.operand) begin
					r.status = ST_MISSING;
				end else if (set_cnts[p] > 1) begin
					set_cnts[p]--;
				end else begin
					set_vals.delete(p);
					set_cnts.delete(p);
				end
			end
			MODE_RANK: begin
				seen = 1;
				for (int i = 0; i < p; i++)
					seen += set_cnts[i];
				r.answer = seen[31:0];
			end
			MODE_KTH: begin
				if (op.operand < 1) begin
					r.status = ST_MISSING;
					r.answer = SENT_LOW;
				end else begin
					seen = 0;
					r.status = ST_MISSING;
					r.answer = SENT_HIGH;
					for (int i = 0; i < set_vals.size(); i++) begin
						seen += set_cnts[i];
						if (op.operand <= seen) begin
							r.status = ST_OK;
							r.answer = set_vals[i];
							break;
						end
					end
				end
			end
			MODE_PRED: begin
				if (p == 0) begin
					r.status = ST_MISSING;
					r.answer = SENT_LOW;
				end else begin
					r.answer = set_vals[p-1];
				end
			end
			MODE_SUCC: begin
				while (p < set_vals.size() && set_vals[p] <= op.operand)
					p++;
				if (p >= set_vals.size()) begin
					r.status = ST_MISSING;
					r.answer = SENT_HIGH;
				end else begin
					r.answer = set_vals[p];
				end
			end
			default: r.status = ST_MISSING;
		endcase
		return r;
	endfunction

	function automatic void add_op(logic [2:0] mode, logic signed [31:0] operand);
		op_t op;
		op.mode = mode;
		op.operand = operand;
		pending_ops.push_back(op);
	endfunction

	// pick a value near the stored ones most of the time
	function automatic logic signed [31:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $signed($urandom_range(0, 40)) - 20;
		else if (sel == 6)
			return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		else if (sel == 7)
			return $urandom_range(0, 1) ? SENT_HIGH : SENT_LOW;
		return $signed($urandom());
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.mode    <= '0;
			in_ch.operand <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(predict_result('{in_ch.mode, in_ch.operand}));
				quiet_cycles = 0;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_ops.size() > 0 && !hold_source
						&& (no_idle || $urandom_range(0, 99) >= 17)) begin
					op_t op;
					op = pending_ops.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.mode    <= op.mode;
					in_ch.operand <= op.operand;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				quiet_cycles = 0;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: answer %0d status %0d",
							out_ch.answer, out_ch.status);
				end else begin
					res_t e;
					e = expected_results.pop_front();
					if (out_ch.answer !== e.answer || out_ch.status !== e.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0d, got %0d/%0d",
								e.answer, e.status, out_ch.answer, out_ch.status);
					end
				end
			end
			out_ch.ready <= !hold_sink && (no_idle || $urandom_range(0, 99) >= 17);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// sample at the falling edge, once the driver and checker have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ops.size() > 0 || in_ch.valid || expected_results.size() > 0);
	endtask

	initial begin
		int unsigned sel;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty queries, extremes, sentinels as data, unused modes
		add_op(MODE_PRED, 0);
		add_op(MODE_SUCC, 0);
		add_op(MODE_KTH, 1);
		add_op(MODE_DELETE, 5);
		add_op(MODE_RANK, 32'sh7fffffff);
		add_op(MODE_INSERT, 32'sh80000000);
		add_op(MODE_INSERT, 32'sh7fffffff);
		add_op(MODE_INSERT, SENT_HIGH);
		add_op(MODE_INSERT, SENT_LOW);
		add_op(MODE_INSERT, SENT_LOW);
		add_op(MODE_RANK, SENT_HIGH);
		add_op(MODE_RANK, 32'sh80000000);
		add_op(MODE_KTH, 0);
		add_op(MODE_KTH, 32'sh80000000);
		add_op(MODE_KTH, 3);
		add_op(MODE_KTH, 32'sh7fffffff);
		add_op(MODE_PRED, 32'sh80000000);
		add_op(MODE_SUCC, 32'sh7fffffff);
		add_op(MODE_PRED, SENT_HIGH);
		add_op(MODE_SUCC, SENT_LOW);
		add_op(MODE_DELETE, SENT_LOW);
		add_op(MODE_DELETE, 32'sh7fffffff);
		add_op(3'd6, 1);
		add_op(3'd7, -1);
		wait_drained();

		// back-pressure: hold the receiver while items keep coming
		for (int i = 0; i < 30; i++)
			add_op(MODE_INSERT, pick_value());
		hold_sink = 1;
		repeat (300) @(posedge clk);
		hold_sink = 0;
		wait_drained();

		// random mix, with an idle-free stretch in the middle
		for (int i = 0; i < 1300; i++) begin
			if (i == 400) begin
				wait_drained();
				no_idle = 1;
			end
			if (i == 650) begin
				wait_drained();
				no_idle = 0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 35)
				add_op(MODE_INSERT, pick_value());
			else if (sel < 55)
				add_op(MODE_DELETE, pick_value());
			else if (sel < 65)
				add_op(MODE_RANK, pick_value());
			else if (sel < 80)
				add_op(MODE_KTH, $urandom_range(0, 9) == 0 ? $signed($urandom())
					: $signed($urandom_range(0, 60)) - 2);
			else if (sel < 89)
				add_op(MODE_PRED, pick_value());
			else if (sel < 98)
				add_op(MODE_SUCC, pick_value());
			else
				add_op(3'($urandom_range(6, 7)), $signed($urandom()));
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
